FILE: hw/rtl/pehi_pkg.sv
// Shared types and constants for the pair exclusion hash insert block.
package pehi_pkg;

   localparam int CFG_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int SLOT_OUT_W  = 12;
   localparam int COUNT_OUT_W = 13;
   localparam int EPOCH_W     = 8;
   localparam int HASH_W      = 32;

   localparam logic [CFG_W-1:0] CFG_LG_RESET = 4'd12;
   localparam logic [CFG_W-1:0] CFG_LG_MIN   = 4'd1;

   localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h9E37_79B9;
   localparam logic [HASH_W-1:0] MIX_ADD   = 32'h85EB_CA6B;
   localparam logic [HASH_W-1:0] MIX_MUL_B = 32'h7FEB_352D;
   localparam int MIX_SHL   = 6;
   localparam int MIX_SHR_A = 2;
   localparam int MIX_SHR_B = 16;
   localparam int MIX_SHR_C = 15;

   // epoch zero marks a cleared entry, so live epochs run from first to last
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

   typedef enum logic [STATUS_W-1:0] {
      ST_SKIP    = 2'd0,
      ST_INSERT  = 2'd1,
      ST_PRESENT = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLEAR,
      S_MUL1,
      S_MIX,
      S_MUL2,
      S_FIN,
      S_PROBE,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/pair_exclusion_hash_insert_top.sv
// Pair exclusion hash table: linear-probing insert of unordered body pairs.
// Flow: an accepted word goes from S_IDLE straight to S_DONE if skipped, else through S_MUL1,
//   S_MIX, S_MUL2, S_FIN and one S_PROBE step per slot probed, then to S_DONE.
// Handshake: one word at a time, taken only in S_IDLE; S_DONE holds the result until the
//   output is free. The shared 32x32 multiplier runs two passes; the probe reads one slot per cycle.
// Reset: clears control state and runs a clearing pass over every entry of the slot RAM;
//   every 255th start_new repeats that clearing pass before its word is handled.
module pair_exclusion_hash_insert_top
   import pehi_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int BODY_BITS   = 20
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // csr
   input  logic                                       csr_wr_en,
   input  logic [CFG_W-1:0]                           csr_wr_data,
   // request
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // first_body, second_body
   input  logic [((2*(BODY_BITS+1)+7)/8)*8-1:0]       req_tdata,
   // start_new, enabled, collide_connected
   input  logic [2:0]                                 req_tuser,
   // response
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // slot_index, entry_count
   output logic [((SLOT_OUT_W+COUNT_OUT_W+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]                        rsp_tuser
);

   localparam int BW         = BODY_BITS + 1;
   localparam int AW         = $clog2(TABLE_DEPTH);
   localparam int CW         = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W    = EPOCH_W + 2 * BW;
   localparam int POW_W      = 17;
   localparam int RSP_DATA_W = ((SLOT_OUT_W + COUNT_OUT_W + 7) / 8) * 8;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     cfg_lg_ff, cfg_lg_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 pend_ff, pend_in;
   logic                 skip_ff, skip_in;
   logic [BW-1:0]        lo_ff, lo_in;
   logic [BW-1:0]        hi_ff, hi_in;
   logic [HASH_W-1:0]    h_ff, h_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [CW-1:0]        probe_ff, probe_in;
   status_type           res_status_ff, res_status_in;
   logic [AW-1:0]        res_slot_ff, res_slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [CFG_W-1:0]     lg_c;
   logic [POW_W-1:0]     pow_c;
   logic [CW-1:0]        size_c;
   logic [AW-1:0]        mask_c;

   logic [BW-1:0]        body_a, body_b;
   logic                 skip_c;

   logic [HASH_W-1:0]    mul_a, mul_b, mul_p;
   logic [HASH_W-1:0]    mix_sum, mix_1, mix_2, fin_h;
   logic [AW-1:0]        slot_hash, slot_next;

   logic                 ram_we;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;
   logic [EPOCH_W-1:0]   ent_tag;
   logic [BW-1:0]        ent_lo, ent_hi;
   logic                 ent_live, ent_hit;
   logic                 out_free;

   // slots in use
   assign lg_c   = (cfg_lg_ff < CFG_LG_MIN) ? CFG_LG_MIN : cfg_lg_ff;
   assign pow_c  = POW_W'(1) << lg_c;
   assign size_c = (pow_c > POW_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(pow_c);
   assign mask_c = AW'(size_c - CW'(1));

   assign body_a = req_tdata[BW-1:0];
   assign body_b = req_tdata[2*BW-1:BW];
   assign skip_c = !req_tuser[1] || req_tuser[2] || body_a[BW-1] || body_b[BW-1];

   // shared multiplier: lo * MIX_MUL_A, then h * MIX_MUL_B
   assign mul_a = (state_ff == S_MUL1) ? HASH_W'(lo_ff) : h_ff;
   assign mul_b = (state_ff == S_MUL1) ? MIX_MUL_A : MIX_MUL_B;
   assign mul_p = mul_a * mul_b;

   assign mix_sum = HASH_W'(hi_ff) + MIX_ADD + (h_ff << MIX_SHL) + (h_ff >> MIX_SHR_A);
   assign mix_1   = h_ff ^ mix_sum;
   assign mix_2   = mix_1 ^ (mix_1 >> MIX_SHR_B);
   assign fin_h   = h_ff ^ (h_ff >> MIX_SHR_C);

   assign slot_hash = fin_h[AW-1:0] & mask_c;
   assign slot_next = AW'(slot_ff + AW'(1)) & mask_c;

   assign ent_tag  = ram_rd_data[ENTRY_W-1 -: EPOCH_W];
   assign ent_hi   = ram_rd_data[2*BW-1:BW];
   assign ent_lo   = ram_rd_data[BW-1:0];
   assign ent_live = (ent_tag == epoch_ff);
   assign ent_hit  = ent_live && (ent_lo == lo_ff) && (ent_hi == hi_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign ram_rd_addr = (state_ff == S_FIN) ? slot_hash : slot_next;

   always_comb begin
      state_in      = state_ff;
      cfg_lg_in     = csr_wr_en ? csr_wr_data : cfg_lg_ff;
      epoch_in      = epoch_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      pend_in       = pend_ff;
      skip_in       = skip_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      h_in          = h_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = {epoch_ff, hi_ff, lo_ff};
      req_tready    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pend_in       = 1'b1;
               skip_in       = skip_c;
               lo_in         = BW'(((body_a < body_b) ? body_a : body_b) + BW'(1));
               hi_in         = BW'(((body_a < body_b) ? body_b : body_a) + BW'(1));
               res_status_in = ST_SKIP;
               res_slot_in   = '0;
               state_in      = skip_c ? S_DONE : S_MUL1;
               if (req_tuser[0]) begin
                  count_in = '0;
                  if (epoch_ff == EPOCH_LAST) begin
                     epoch_in    = EPOCH_FIRST;
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
               end
            end
         end
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = AW'(clr_addr_ff + AW'(1));
            if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
               if (!pend_ff) begin
                  state_in = S_IDLE;
               end else if (skip_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            h_in     = mul_p;
            state_in = S_MIX;
         end
         S_MIX: begin
            h_in     = mix_2;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            h_in     = mul_p;
            state_in = S_FIN;
         end
         S_FIN: begin
            slot_in  = slot_hash;
            probe_in = '0;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (ent_hit) begin
               res_status_in = ST_PRESENT;
               res_slot_in   = slot_ff;
               state_in      = S_DONE;
            end else if (!ent_live) begin
               ram_we        = 1'b1;
               count_in      = CW'(count_ff + CW'(1));
               res_status_in = ST_INSERT;
               res_slot_in   = slot_ff;
               state_in      = S_DONE;
            end else if (probe_ff == CW'(size_c - CW'(1))) begin
               res_status_in = ST_FULL;
               res_slot_in   = '0;
               state_in      = S_DONE;
            end else begin
               slot_in  = slot_next;
               probe_in = CW'(probe_ff + CW'(1));
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_OUT_W'(res_slot_ff);
               rsp_count_in  = COUNT_OUT_W'(count_ff);
               pend_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cfg_lg_ff    <= CFG_LG_RESET;
         epoch_ff     <= EPOCH_FIRST;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_lg_ff    <= cfg_lg_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      skip_ff       <= skip_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      h_ff          <= h_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   pehi_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_slot_ff});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("occupied count above table depth");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("live epoch collides with cleared tag");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && ram_we) |=> count_ff == CW'($past(count_ff) + CW'(1)))
      else $error("insert did not bump occupied count");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> probe_ff < size_c)
      else $error("probe ran past slots in use");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> rsp_slot_ff == '0)
      else $error("full status with nonzero slot");

endmodule

FILE: hw/rtl/pehi_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module pehi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/exclusion_checker.sv
`timescale 1ns / 100ps
// Watches the request and response streams, predicts each response and compares it.
module exclusion_checker
   import pehi_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int BODY_BITS   = 20
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wr_en,
   input  logic [CFG_W-1:0]                            csr_wr_data,
   input  logic                                        req_tvalid,
   input  logic                                        req_tready,
   input  logic [((2*(BODY_BITS+1)+7)/8)*8-1:0]        req_tdata,
   input  logic [2:0]                                  req_tuser,
   input  logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   input  logic [((SLOT_OUT_W+COUNT_OUT_W+7)/8)*8-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]                         rsp_tuser,
   output int                                          mismatch_count,
   output int                                          pending_count
);

   localparam int BW = BODY_BITS + 1;

   typedef struct packed {
      status_type              status;
      logic [SLOT_OUT_W-1:0]   slot;
      logic [COUNT_OUT_W-1:0]  count;
   } outcome_type;

   int unsigned     pair_lo [TABLE_DEPTH];
   int unsigned     pair_hi [TABLE_DEPTH];
   int unsigned     occupied;
   logic [CFG_W-1:0] size_lg;
   outcome_type     pending_outcomes [$];
   int              errors = 0;

   assign mismatch_count = errors;

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      if (errors < 200)
         $display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      errors++;
   endtask

   function automatic logic [HASH_W-1:0] pair_hash(logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
      logic [HASH_W-1:0] h;
      h = a * MIX_MUL_A;
      h = h ^ (b + MIX_ADD + (h << MIX_SHL) + (h >> MIX_SHR_A));
      h = h ^ (h >> MIX_SHR_B);
      h = h * MIX_MUL_B;
      h = h ^ (h >> MIX_SHR_C);
      return h;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pair_lo[i] = 0;
         pair_hi[i] = 0;
      end
      occupied = 0;
   endfunction

   function automatic outcome_type insert_pair(logic [2:0] flags, logic [BW-1:0] fa,
                                               logic [BW-1:0] fb);
      outcome_type o;
      int unsigned lo, hi, lg, size, mask, slot;
      bit          done;
      if (flags[0])
         wipe_table();
      o.status = ST_SKIP;
      o.slot   = '0;
      if (flags[1] && !flags[2] && !fa[BW-1] && !fb[BW-1]) begin
         lo = ((fa < fb) ? fa : fb) + 1;
         hi = ((fa < fb) ? fb : fa) + 1;
         lg = (size_lg < CFG_LG_MIN) ? CFG_LG_MIN : size_lg;
         size = 1 << lg;
         if (size > TABLE_DEPTH)
            size = TABLE_DEPTH;
         mask = size - 1;
         slot = pair_hash(lo, hi) & mask;
         o.status = ST_FULL;
         done = 0;
         for (int n = 0; n < size && !done; n++) begin
            if (pair_lo[slot] == lo && pair_hi[slot] == hi) begin
               o.status = ST_PRESENT;
               o.slot   = SLOT_OUT_W'(slot);
               done     = 1;
            end else if (pair_lo[slot] == 0) begin
               pair_lo[slot] = lo;
               pair_hi[slot] = hi;
               occupied++;
               o.status = ST_INSERT;
               o.slot   = SLOT_OUT_W'(slot);
               done     = 1;
            end else begin
               slot = (slot + 1) & mask;
            end
         end
      end
      o.count = COUNT_OUT_W'(occupied);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         wipe_table();
         size_lg = CFG_LG_RESET;
         pending_outcomes.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en)
            size_lg = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               report("unexpected word", 32'(rsp_tuser), 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tuser !== want.status)
                  report("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[SLOT_OUT_W-1:0] !== want.slot)
                  report("slot", 32'(rsp_tdata[SLOT_OUT_W-1:0]), 32'(want.slot));
               if (rsp_tdata[SLOT_OUT_W +: COUNT_OUT_W] !== want.count)
                  report("entry_count", 32'(rsp_tdata[SLOT_OUT_W +: COUNT_OUT_W]),
                         32'(want.count));
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.insert(pending_outcomes.size(),
                                    insert_pair(req_tuser, req_tdata[BW-1:0],
                                                req_tdata[2*BW-1:BW]));
         pending_count <= pending_outcomes.size();
      end
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Stimulus, reset and verdict for the pair exclusion hash insert block.
module testbench;
   import pehi_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int BODY_BITS   = 20;
   localparam int BW          = BODY_BITS + 1;
   localparam int REQ_W       = ((2*BW+7)/8)*8;
   localparam int RSP_W       = ((SLOT_OUT_W+COUNT_OUT_W+7)/8)*8;
   localparam logic [BW-1:0] BODY_MAX  = BW'((1 << BODY_BITS) - 1);
   localparam logic [BW-1:0] BODY_NONE = '1;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic [2:0]       req_tuser   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   int   mismatches, pending;
   bit   calm = 0;
   logic [BW-1:0] recent_a [$];
   logic [BW-1:0] recent_b [$];
   logic [CFG_W-1:0] phase_lg [10] = '{4'd12, 4'd1, 4'd4, 4'd0, 4'd15,
                                       4'd6, 4'd9, 4'd2, 4'd3, 4'd12};

   pair_exclusion_hash_insert_top #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .BODY_BITS  (BODY_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   exclusion_checker #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .BODY_BITS  (BODY_BITS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .mismatch_count(mismatches),
      .pending_count (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 31);
   end

   task automatic put(bit st, bit en, bit cc, logic [BW-1:0] fa, logic [BW-1:0] fb);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-2*BW){1'b0}}, fb, fa};
      req_tuser  <= {cc, en, st};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic set_size(logic [CFG_W-1:0] lg);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lg;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_word(int start_pct);
      logic [BW-1:0] fa, fb;
      int            k, r;
      r = $urandom_range(99);
      if (r < 35 && recent_a.size() > 0) begin
         k = $urandom_range(recent_a.size() - 1);
         if ($urandom_range(1)) begin
            fa = recent_a[k];
            fb = recent_b[k];
         end else begin
            fa = recent_b[k];
            fb = recent_a[k];
         end
      end else if (r < 75) begin
         fa = BW'($urandom_range(63));
         fb = BW'($urandom_range(63));
      end else begin
         fa = BW'($urandom_range(BODY_MAX));
         fb = BW'($urandom_range(BODY_MAX));
      end
      if ($urandom_range(99) < 4)
         fa = BODY_NONE;
      if ($urandom_range(99) < 4)
         fb = BODY_NONE;
      recent_a.insert(recent_a.size(), fa);
      recent_b.insert(recent_b.size(), fb);
      if (recent_a.size() > 16) begin
         recent_a.delete(0);
         recent_b.delete(0);
      end
      put($urandom_range(99) < start_pct, $urandom_range(99) < 92,
          $urandom_range(99) < 8, fa, fb);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: skips, extremes, duplicates, clear on a skipped word
      put(0, 0, 0, 5, 7);
      put(0, 1, 1, 5, 7);
      put(0, 1, 0, BODY_NONE, 7);
      put(0, 1, 0, 7, BODY_NONE);
      put(0, 1, 0, 0, 0);
      put(0, 1, 0, BODY_MAX, BODY_MAX);
      put(0, 1, 0, 5, 3);
      put(0, 1, 0, 3, 5);
      put(0, 1, 0, 0, BODY_MAX);
      put(1, 0, 0, 0, 0);
      put(0, 1, 0, 3, 5);
      put(0, 1, 0, 0, 0);
      // two-slot table filled up
      set_size(4'd1);
      put(1, 1, 0, 1, 2);
      put(0, 1, 0, 3, 4);
      put(0, 1, 0, 5, 6);
      put(0, 1, 0, 2, 1);
      put(0, 1, 1, BODY_NONE, BODY_NONE);
      set_size(4'd0);
      put(0, 1, 0, 9, 10);
      put(0, 1, 0, 4, 3);
      set_size(4'd12);
      put(0, 1, 0, 1, 2);
      put(0, 1, 0, 11, 12);
      set_size(4'd15);
      put(0, 1, 0, BODY_MAX, 0);

      for (int p = 0; p < 10; p++) begin
         set_size(phase_lg[p]);
         calm = (p == 4);
         for (int i = 0; i < 80; i++)
            random_word(3);
         calm = 0;
      end

      // long run of clears to reach the periodic full wipe
      set_size(4'd5);
      for (int i = 0; i < 270; i++)
         random_word(100);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/pehi_pkg.sv
hw/rtl/pehi_ram.sv
hw/rtl/pair_exclusion_hash_insert_top.sv
test/exclusion_checker.sv
test/testbench.sv
